// File: src/vmc_pkg.sv
// ----------------------------------------------------------------------------
// vmc_pkg: shared types and constants for the vector magnitude clamp
// Item structs, status codes, register indexes and pipeline depths.
// ----------------------------------------------------------------------------
package vmc_pkg;

  localparam int COMP_W      = 32;
  localparam int LEN_W       = 31;
  localparam int SQ_W        = 64;
  localparam int PROD_W      = 63;
  localparam int ROOT_W      = 32;
  localparam int QUO_W       = 33;
  localparam int LANES       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = QUO_W + 1;

  typedef enum logic [1:0] {
    ST_UNCHANGED = 2'd0,
    ST_RAISED    = 2'd1,
    ST_LOWERED   = 2'd2,
    ST_ZERO      = 2'd3
  } clamp_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] vec_x;
    logic signed [COMP_W-1:0] vec_y;
    logic signed [COMP_W-1:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic [1:0]               clamp_status;
  } out_item_t;

  typedef struct packed {
    logic [LANES-1:0][COMP_W-1:0] raw;
    logic [LANES-1:0]             neg;
    clamp_status_t                status;
  } side_t;

endpackage

// File: src/vmc_lane_front.sv
// ----------------------------------------------------------------------------
// vmc_lane_front: per-component magnitude and square
// Two register stages: sign/magnitude split, then the exact square.
// ----------------------------------------------------------------------------
module vmc_lane_front (
  input  logic                             clk,
  input  logic [vmc_pkg::COMP_W-1:0]       comp,
  output logic [vmc_pkg::COMP_W-1:0]       mag,
  output logic                             neg,
  output logic [vmc_pkg::SQ_W-1:0]         sq
);

  logic [vmc_pkg::COMP_W-1:0] mag_a;
  logic                       neg_a;

  always_ff @(posedge clk) begin
    neg_a <= comp[vmc_pkg::COMP_W-1];
    mag_a <= comp[vmc_pkg::COMP_W-1] ? (~comp + 1'b1) : comp;
    sq    <= vmc_pkg::SQ_W'(mag_a) * vmc_pkg::SQ_W'(mag_a);
    mag   <= mag_a;
    neg   <= neg_a;
  end

endmodule

// File: src/vmc_isqrt.sv
// ----------------------------------------------------------------------------
// vmc_isqrt: pipelined integer square root
// One result bit per stage; the root is floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module vmc_isqrt (
  input  logic                        clk,
  input  logic [vmc_pkg::SQ_W-1:0]    radicand,
  output logic [vmc_pkg::ROOT_W-1:0]  root
);

  localparam int N = vmc_pkg::SQRT_STAGES;
  localparam int W = vmc_pkg::SQ_W;

  logic [W-1:0] rem_st [N];
  logic [W-1:0] res_st [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
    logic [W-1:0] v_in;
    logic [W-1:0] r_in;
    logic [W-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = rem_st[k-1];
      assign r_in = res_st[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (v_in >= trial) begin
        rem_st[k] <= v_in - trial;
        res_st[k] <= (r_in >> 1) + BIT;
      end else begin
        rem_st[k] <= v_in;
        res_st[k] <= r_in >> 1;
      end
    end
  end

  assign root = res_st[N-1][vmc_pkg::ROOT_W-1:0];

endmodule

// File: src/vmc_div_lane.sv
// ----------------------------------------------------------------------------
// vmc_div_lane: pipelined restoring divider for one lane
// Overflow check, then one quotient bit per stage; overflow gives all ones.
// ----------------------------------------------------------------------------
module vmc_div_lane (
  input  logic                        clk,
  input  logic [vmc_pkg::PROD_W-1:0]  dividend,
  input  logic [vmc_pkg::ROOT_W-1:0]  divisor,
  output logic [vmc_pkg::QUO_W-1:0]   quotient
);

  localparam int QW = vmc_pkg::QUO_W;
  localparam int RW = vmc_pkg::ROOT_W;
  localparam int PW = vmc_pkg::PROD_W;

  logic [RW-1:0] rem_st [QW+1];
  logic [QW-1:0] nlo_st [QW+1];
  logic [RW-1:0] dsr_st [QW+1];
  logic [QW-1:0] quo_st [QW+1];
  logic          ovf_st [QW+1];

  // Quotient at or above 2^QW cannot be built bit by bit: flag it up front
  always_ff @(posedge clk) begin
    rem_st[0] <= RW'(dividend[PW-1:QW]);
    nlo_st[0] <= dividend[QW-1:0];
    dsr_st[0] <= divisor;
    quo_st[0] <= '0;
    ovf_st[0] <= RW'(dividend[PW-1:QW]) >= divisor;
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [RW:0] trial;
    logic        ge;

    assign trial = {rem_st[j-1], nlo_st[j-1][QW-j]};
    assign ge    = trial >= {1'b0, dsr_st[j-1]};

    always_ff @(posedge clk) begin
      rem_st[j] <= ge ? RW'(trial - {1'b0, dsr_st[j-1]}) : RW'(trial);
      quo_st[j] <= {quo_st[j-1][QW-2:0], ge};
      nlo_st[j] <= nlo_st[j-1];
      dsr_st[j] <= dsr_st[j-1];
      ovf_st[j] <= ovf_st[j-1];
    end
  end

  assign quotient = ovf_st[QW] ? '1 : quo_st[QW];

endmodule

// File: src/vector3_magnitude_clamp.sv
// ----------------------------------------------------------------------------
// vector3_magnitude_clamp: clamp the length of a Q16.16 3D vector
// Three lanes square, scale and divide the components; the merge stage
// saturates each lane and picks scaled or original values by status.
// ----------------------------------------------------------------------------
// done strobes once an accepted item has passed v1 to v4, valid_pipe and the done register.
// Throughput: one item per cycle; busy is low except during reset.
// The depth is set by the 32-stage square root and the 34-stage lane divider.
// Reset clears the valid pipeline and sets min_length 0, max_length 1.0.
// Results are shown for one cycle only; the receiver cannot stall them.
module vector3_magnitude_clamp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  vmc_pkg::in_item_t                 vec,
  output logic                              done,
  output vmc_pkg::out_item_t                result,
  input  logic                              cfg_we,
  input  logic [vmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vmc_pkg::LEN_W-1:0]         cfg_wdata
);

  localparam int L          = vmc_pkg::LANES;
  localparam int CW         = vmc_pkg::COMP_W;
  localparam int PROD_DEPTH = vmc_pkg::SQRT_STAGES;
  localparam int SIDE_DEPTH = vmc_pkg::SQRT_STAGES + vmc_pkg::DIV_STAGES;
  localparam int LATENCY    = SIDE_DEPTH + 5;

  logic [vmc_pkg::LEN_W-1:0]   min_length;
  logic [vmc_pkg::LEN_W-1:0]   max_length;
  logic [2*vmc_pkg::LEN_W-1:0] min_sq;
  logic [2*vmc_pkg::LEN_W-1:0] max_sq;

  logic                        accept;
  logic [L-1:0][CW-1:0]        comp_in;
  logic [L-1:0][CW-1:0]        mag_f;
  logic [L-1:0]                neg_f;
  logic [L-1:0][vmc_pkg::SQ_W-1:0] sq_f;

  logic                        v1, v2, v3, v4;
  logic [L-1:0][CW-1:0]        raw1, raw2, raw3, raw4;
  logic [L-1:0][CW-1:0]        mag3, mag4;
  logic [L-1:0]                neg3, neg4;
  logic [vmc_pkg::SQ_W-1:0]    sum3, sum4;
  vmc_pkg::clamp_status_t      status4;
  logic [vmc_pkg::LEN_W-1:0]   target4;

  logic [L-1:0][vmc_pkg::PROD_W-1:0] prod_pipe [PROD_DEPTH];
  vmc_pkg::side_t              side_pipe [SIDE_DEPTH];
  logic [SIDE_DEPTH-1:0]       valid_pipe;
  logic [vmc_pkg::ROOT_W-1:0]  root;
  logic [L-1:0][vmc_pkg::QUO_W-1:0] quo;

  vmc_pkg::side_t              side_last;
  vmc_pkg::out_item_t          result_next;
  logic [L-1:0][CW-1:0]        lane_out;

  function automatic logic [CW-1:0] sat_pack(input logic neg,
                                             input logic [vmc_pkg::QUO_W-1:0] q);
    logic [vmc_pkg::QUO_W-1:0] m;
    begin
      if (neg) begin
        m = (q > (vmc_pkg::QUO_W'(1) << (CW - 1))) ? (vmc_pkg::QUO_W'(1) << (CW - 1)) : q;
        sat_pack = CW'(~m + 1'b1);
      end else begin
        m = (q > vmc_pkg::QUO_W'({1'b0, {(CW-1){1'b1}}})) ?
            vmc_pkg::QUO_W'({1'b0, {(CW-1){1'b1}}}) : q;
        sat_pack = m[CW-1:0];
      end
    end
  endfunction

  assign busy    = rst;
  assign accept  = start && !busy;
  assign comp_in = {vec.vec_x, vec.vec_y, vec.vec_z};

  // Configuration registers and the squared bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
      max_length <= vmc_pkg::LEN_W'(64'(1) << FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_index)
        vmc_pkg::REG_MIN_LENGTH: min_length <= cfg_wdata;
        vmc_pkg::REG_MAX_LENGTH: max_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    min_sq <= (2*vmc_pkg::LEN_W)'(min_length) * (2*vmc_pkg::LEN_W)'(min_length);
    max_sq <= (2*vmc_pkg::LEN_W)'(max_length) * (2*vmc_pkg::LEN_W)'(max_length);
  end

  for (genvar i = 0; i < L; i++) begin : g_front
    vmc_lane_front u_front (
      .clk  (clk),
      .comp (comp_in[i]),
      .mag  (mag_f[i]),
      .neg  (neg_f[i]),
      .sq   (sq_f[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    raw1 <= comp_in;
    raw2 <= raw1;
    raw3 <= raw2;
    raw4 <= raw3;
    sum3 <= sq_f[0] + sq_f[1] + sq_f[2];
    mag3 <= mag_f;
    neg3 <= neg_f;
    sum4 <= sum3;
    mag4 <= mag3;
    neg4 <= neg3;
    // Zero is tested first, then the lower bound before the upper, as min may exceed max
    if (sum3 == '0) begin
      status4 <= vmc_pkg::ST_ZERO;
      target4 <= '0;
    end else if (sum3 < vmc_pkg::SQ_W'(min_sq)) begin
      status4 <= vmc_pkg::ST_RAISED;
      target4 <= min_length;
    end else if (sum3 > vmc_pkg::SQ_W'(max_sq)) begin
      status4 <= vmc_pkg::ST_LOWERED;
      target4 <= max_length;
    end else begin
      status4 <= vmc_pkg::ST_UNCHANGED;
      target4 <= '0;
    end
  end

  vmc_isqrt u_isqrt (
    .clk      (clk),
    .radicand (sum4),
    .root     (root)
  );

  // Hold products and side data alongside the root and divider pipelines
  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      prod_pipe[0][i] <= vmc_pkg::PROD_W'(mag4[i]) * vmc_pkg::PROD_W'(target4);
    end
    for (int k = 1; k < PROD_DEPTH; k++) begin
      prod_pipe[k] <= prod_pipe[k-1];
    end
    side_pipe[0] <= '{raw: raw4, neg: neg4, status: status4};
    for (int k = 1; k < SIDE_DEPTH; k++) begin
      side_pipe[k] <= side_pipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[SIDE_DEPTH-2:0], v4};
    end
  end

  for (genvar i = 0; i < L; i++) begin : g_div
    vmc_div_lane u_div (
      .clk      (clk),
      .dividend (prod_pipe[PROD_DEPTH-1][i]),
      .divisor  (root),
      .quotient (quo[i])
    );
  end

  // Merge: saturate scaled lanes or pass the original components
  assign side_last = side_pipe[SIDE_DEPTH-1];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      if (side_last.status == vmc_pkg::ST_RAISED ||
          side_last.status == vmc_pkg::ST_LOWERED) begin
        lane_out[i] = sat_pack(side_last.neg[i], quo[i]);
      end else begin
        lane_out[i] = side_last.raw[i];
      end
    end
    result_next.out_x        = lane_out[2];
    result_next.out_y        = lane_out[1];
    result_next.out_z        = lane_out[0];
    result_next.clamp_status = side_last.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_pipe[SIDE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef SYNTH
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted item");

  a_zero_vector_out: assert property (@(posedge clk) disable iff (rst)
    (done && result.clamp_status == vmc_pkg::ST_ZERO) |->
      (result.out_x == '0 && result.out_y == '0 && result.out_z == '0))
    else $error("zero-vector item produced nonzero components");

  a_unchanged_pass: assert property (@(posedge clk) disable iff (rst)
    (done && result.clamp_status == vmc_pkg::ST_UNCHANGED) |->
      (result.out_x == $past(vec.vec_x, LATENCY) &&
       result.out_y == $past(vec.vec_y, LATENCY) &&
       result.out_z == $past(vec.vec_z, LATENCY)))
    else $error("unchanged item does not match its input");
`endif

endmodule
